>>> src/ttcb_pkg.sv
// shared types and constants for the text terminal character buffer
// used by every module of the block; depends on nothing

package ttcb_pkg;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 64;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(CELLS);

  localparam int KIND_W   = 3;
  localparam int CHAR_W   = 8;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 6;
  localparam int WIDTH_W  = 8;
  localparam int HEIGHT_W = 7;
  localparam int CFG_IDX_W = 1;

  // remainder unit works on column sized dividends
  localparam int MOD_W    = COL_W;
  localparam int PROD_W   = ROW_W + WIDTH_W;
  localparam int ADDR_X_W = PROD_W + 1;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 8'd80;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 7'd30;

  typedef enum logic [KIND_W-1:0] {
    K_TEXT   = 3'd0,
    K_RAW    = 3'd1,
    K_SETCUR = 3'd2,
    K_CLEAR  = 3'd3,
    K_READ   = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MOD_COL,
    S_MOD_ROW,
    S_ADDR,
    S_ACCESS,
    S_RDATA,
    S_SCROLL_BASE,
    S_SCROLL,
    S_CLEAR,
    S_FIN
  } state_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [ADDR_W-1:0]  addr;
    logic [CHAR_W-1:0]  wdata;
  } ram_req_t;

  typedef struct packed {
    logic               start;
    logic [MOD_W-1:0]   dividend;
    logic [WIDTH_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] rem;
  } mod_rsp_t;

endpackage

>>> src/ttcb_cell_ram.sv
// single port cell store, one byte per character cell, registered read
// depends on ttcb_pkg for the request struct and sizes

module ttcb_cell_ram (
  input  logic                           clk,
  input  ttcb_pkg::ram_req_t             req,
  output logic [ttcb_pkg::CHAR_W-1:0]    rd_data
);

  logic [ttcb_pkg::CHAR_W-1:0] mem [ttcb_pkg::CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

>>> src/ttcb_mod_unit.sv
// iterative remainder unit, one dividend bit per cycle (restoring)
// depends on ttcb_pkg for the request and response structs

module ttcb_mod_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  ttcb_pkg::mod_req_t req,
  output ttcb_pkg::mod_rsp_t rsp
);

  localparam int CNT_W = $clog2(ttcb_pkg::MOD_W);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [ttcb_pkg::MOD_W-1:0]    dvd_r, dvd_nxt;
  logic [ttcb_pkg::WIDTH_W-1:0]  dvs_r, dvs_nxt;
  logic [ttcb_pkg::MOD_W-1:0]    rem_r, rem_nxt;
  logic [ttcb_pkg::MOD_W:0]      trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    // partial remainder stays below the divisor, so one more bit fits
    trial    = {rem_r, dvd_r[ttcb_pkg::MOD_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(ttcb_pkg::MOD_W - 1);
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = dvd_r << 1;
      if (trial >= (ttcb_pkg::MOD_W + 1)'(dvs_r)) begin
        rem_nxt = ttcb_pkg::MOD_W'(trial - (ttcb_pkg::MOD_W + 1)'(dvs_r));
      end else begin
        rem_nxt = ttcb_pkg::MOD_W'(trial);
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

>>> src/text_terminal_char_buffer_core.sv
// top level of the text terminal character buffer: sequencer, cursor state, output register
// depends on ttcb_pkg, ttcb_cell_ram and ttcb_mod_unit

// Character terminal over a 64 x 128 byte cell store with a cursor and a ring top pointer.
// One request is worked at a time and each gives one result. A write that wraps the line
// zeroes the scrolled row one cell per cycle on the single memory port; a carriage return
// works one remainder in the remainder unit (one bit per cycle); a newline works one and
// zeroes a row for its scroll; set cursor works two remainders, read cell two and a read;
// clear zeroes every cell, one a cycle. A stalled output holds a new result back, and the
// next request is accepted from the cycle after the result is loaded. The store holds no
// defined contents after reset: read only cells that a clear or a write has set. Width and
// height must be written only while the block is idle; the block itself does not enforce
// this. Values out of range are saturated to 1..128 and 1..64, height from its low 7 bits.

module text_terminal_char_buffer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ttcb_pkg::KIND_W-1:0]       in_kind,
  input  logic [ttcb_pkg::CHAR_W-1:0]       in_char_code,
  input  logic                              in_auto_advance,
  input  logic [ttcb_pkg::COL_W-1:0]        in_col,
  input  logic [ttcb_pkg::ROW_W-1:0]        in_row,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ttcb_pkg::COL_W-1:0]        out_cursor_col,
  output logic [ttcb_pkg::ROW_W-1:0]        out_cursor_row,
  output logic [ttcb_pkg::ROW_W-1:0]        out_top_row,
  output logic [ttcb_pkg::CHAR_W-1:0]       out_read_char,
  input  logic                              cfg_we,
  input  logic [ttcb_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [ttcb_pkg::WIDTH_W-1:0]      cfg_data
);

  ttcb_pkg::state_t state_r, state_nxt;

  logic [ttcb_pkg::KIND_W-1:0]   kind_r, kind_nxt;
  logic [ttcb_pkg::CHAR_W-1:0]   ch_r, ch_nxt;
  logic                          adv_r, adv_nxt;
  logic [ttcb_pkg::COL_W-1:0]    col_r, col_nxt;
  logic [ttcb_pkg::ROW_W-1:0]    row_r, row_nxt;

  logic [ttcb_pkg::COL_W-1:0]    cur_col_r, cur_col_nxt;
  logic [ttcb_pkg::ROW_W-1:0]    cur_row_r, cur_row_nxt;
  logic [ttcb_pkg::ROW_W-1:0]    top_r, top_nxt;
  logic [ttcb_pkg::WIDTH_W-1:0]  width_r;
  logic [ttcb_pkg::HEIGHT_W-1:0] height_r;

  logic [ttcb_pkg::COL_W-1:0]    col_mod_r, col_mod_nxt;
  logic [ttcb_pkg::ROW_W-1:0]    row_mod_r, row_mod_nxt;
  logic [ttcb_pkg::PROD_W-1:0]   prod_r, prod_nxt;
  logic [ttcb_pkg::COL_W-1:0]    cnt_r, cnt_nxt;
  logic [ttcb_pkg::ADDR_W-1:0]   clr_r, clr_nxt;
  logic                          oob_r, oob_nxt;
  logic [ttcb_pkg::CHAR_W-1:0]   rd_char_r, rd_char_nxt;

  logic                          out_valid_r;
  logic [ttcb_pkg::COL_W-1:0]    out_col_r;
  logic [ttcb_pkg::ROW_W-1:0]    out_row_r;
  logic [ttcb_pkg::ROW_W-1:0]    out_top_r;
  logic [ttcb_pkg::CHAR_W-1:0]   out_char_r;
  logic                          out_load;

  logic [ttcb_pkg::WIDTH_W-1:0]  w_eff;
  logic [ttcb_pkg::HEIGHT_W-1:0] h_eff;
  logic [ttcb_pkg::ROW_W-1:0]    mul_a;
  logic [ttcb_pkg::PROD_W-1:0]   mul_p;
  logic [ttcb_pkg::COL_W-1:0]    acc_col;
  logic [ttcb_pkg::ADDR_X_W-1:0] acc_addr;
  logic [ttcb_pkg::ADDR_X_W-1:0] scr_addr;
  logic                          acc_oob;
  logic                          scr_oob;
  logic                          do_adv;
  logic [ttcb_pkg::WIDTH_W-1:0]  col_inc;
  logic [ttcb_pkg::HEIGHT_W-1:0] row_inc;
  logic [ttcb_pkg::HEIGHT_W-1:0] top_inc;
  logic                          is_read;

  ttcb_pkg::ram_req_t            ram_req;
  logic [ttcb_pkg::CHAR_W-1:0]   ram_rdata;
  ttcb_pkg::mod_req_t            mod_req;
  ttcb_pkg::mod_rsp_t            mod_rsp;

  ttcb_cell_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rdata)
  );

  ttcb_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  // saturated geometry
  always_comb begin
    if (width_r == '0) begin
      w_eff = ttcb_pkg::WIDTH_W'(1);
    end else if (width_r > ttcb_pkg::WIDTH_W'(ttcb_pkg::MAX_COLS)) begin
      w_eff = ttcb_pkg::WIDTH_W'(ttcb_pkg::MAX_COLS);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = ttcb_pkg::HEIGHT_W'(1);
    end else if (height_r > ttcb_pkg::HEIGHT_W'(ttcb_pkg::MAX_ROWS)) begin
      h_eff = ttcb_pkg::HEIGHT_W'(ttcb_pkg::MAX_ROWS);
    end else begin
      h_eff = height_r;
    end
  end

  assign is_read = (kind_r == ttcb_pkg::K_READ);

  // shared row times width multiplier, result registered in prod_r
  assign mul_a = (state_r == ttcb_pkg::S_SCROLL_BASE) ? top_r :
                 (is_read ? row_mod_r : cur_row_r);
  assign mul_p = ttcb_pkg::PROD_W'(mul_a) * ttcb_pkg::PROD_W'(w_eff);

  assign acc_col  = is_read ? col_mod_r : cur_col_r;
  assign acc_addr = ttcb_pkg::ADDR_X_W'(prod_r) + ttcb_pkg::ADDR_X_W'(acc_col);
  assign scr_addr = ttcb_pkg::ADDR_X_W'(prod_r) + ttcb_pkg::ADDR_X_W'(cnt_r);
  assign acc_oob  = acc_addr >= ttcb_pkg::ADDR_X_W'(ttcb_pkg::CELLS);
  assign scr_oob  = scr_addr >= ttcb_pkg::ADDR_X_W'(ttcb_pkg::CELLS);

  assign do_adv  = ((kind_r == ttcb_pkg::K_TEXT) || adv_r) && (ch_r != '0);
  assign col_inc = ttcb_pkg::WIDTH_W'(cur_col_r) + 1'b1;
  assign row_inc = ttcb_pkg::HEIGHT_W'(cur_row_r) + 1'b1;
  assign top_inc = ttcb_pkg::HEIGHT_W'(top_r) + 1'b1;

  assign in_stall = (state_r != ttcb_pkg::S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    ch_nxt      = ch_r;
    adv_nxt     = adv_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    top_nxt     = top_r;
    col_mod_nxt = col_mod_r;
    row_mod_nxt = row_mod_r;
    prod_nxt    = prod_r;
    cnt_nxt     = cnt_r;
    clr_nxt     = clr_r;
    oob_nxt     = oob_r;
    rd_char_nxt = rd_char_r;
    out_load    = 1'b0;
    ram_req     = '0;
    mod_req     = '0;

    unique case (state_r)
      ttcb_pkg::S_IDLE: begin
        if (in_valid) begin
          kind_nxt    = in_kind;
          ch_nxt      = in_char_code;
          adv_nxt     = in_auto_advance;
          col_nxt     = in_col;
          row_nxt     = in_row;
          rd_char_nxt = '0;
          state_nxt   = ttcb_pkg::S_DECODE;
        end
      end

      ttcb_pkg::S_DECODE: begin
        unique case (kind_r)
          ttcb_pkg::K_TEXT: begin
            if (ch_r == ttcb_pkg::CH_NEWLINE) begin
              mod_req.start    = 1'b1;
              mod_req.dividend = row_inc;
              mod_req.divisor  = ttcb_pkg::WIDTH_W'(h_eff);
              state_nxt        = ttcb_pkg::S_MOD_ROW;
            end else if (ch_r == ttcb_pkg::CH_RETURN) begin
              mod_req.start    = 1'b1;
              mod_req.dividend = ttcb_pkg::MOD_W'(cur_row_r);
              mod_req.divisor  = ttcb_pkg::WIDTH_W'(h_eff);
              state_nxt        = ttcb_pkg::S_MOD_ROW;
            end else begin
              state_nxt = ttcb_pkg::S_ADDR;
            end
          end
          ttcb_pkg::K_RAW: begin
            state_nxt = ttcb_pkg::S_ADDR;
          end
          ttcb_pkg::K_SETCUR, ttcb_pkg::K_READ: begin
            mod_req.start    = 1'b1;
            mod_req.dividend = col_r;
            mod_req.divisor  = w_eff;
            state_nxt        = ttcb_pkg::S_MOD_COL;
          end
          ttcb_pkg::K_CLEAR: begin
            clr_nxt   = '0;
            state_nxt = ttcb_pkg::S_CLEAR;
          end
          default: begin
            state_nxt = ttcb_pkg::S_FIN;
          end
        endcase
      end

      ttcb_pkg::S_MOD_COL: begin
        if (mod_rsp.done) begin
          col_mod_nxt      = mod_rsp.rem;
          mod_req.start    = 1'b1;
          mod_req.dividend = ttcb_pkg::MOD_W'(row_r);
          mod_req.divisor  = ttcb_pkg::WIDTH_W'(h_eff);
          state_nxt        = ttcb_pkg::S_MOD_ROW;
        end
      end

      ttcb_pkg::S_MOD_ROW: begin
        if (mod_rsp.done) begin
          row_mod_nxt = ttcb_pkg::ROW_W'(mod_rsp.rem);
          if (kind_r == ttcb_pkg::K_READ) begin
            state_nxt = ttcb_pkg::S_ADDR;
          end else if (kind_r == ttcb_pkg::K_SETCUR) begin
            cur_col_nxt = col_mod_r;
            cur_row_nxt = ttcb_pkg::ROW_W'(mod_rsp.rem);
            state_nxt   = ttcb_pkg::S_FIN;
          end else if (ch_r == ttcb_pkg::CH_NEWLINE) begin
            cur_col_nxt = '0;
            cur_row_nxt = ttcb_pkg::ROW_W'(mod_rsp.rem);
            state_nxt   = ttcb_pkg::S_SCROLL_BASE;
          end else begin
            cur_col_nxt = '0;
            cur_row_nxt = ttcb_pkg::ROW_W'(mod_rsp.rem);
            state_nxt   = ttcb_pkg::S_FIN;
          end
        end
      end

      ttcb_pkg::S_ADDR: begin
        prod_nxt  = mul_p;
        state_nxt = ttcb_pkg::S_ACCESS;
      end

      ttcb_pkg::S_ACCESS: begin
        ram_req.addr = ttcb_pkg::ADDR_W'(acc_addr);
        if (is_read) begin
          ram_req.re = 1'b1;
          oob_nxt    = acc_oob;
          state_nxt  = ttcb_pkg::S_RDATA;
        end else begin
          ram_req.we    = !acc_oob;
          ram_req.wdata = ch_r;
          state_nxt     = ttcb_pkg::S_FIN;
          if (do_adv) begin
            if (col_inc >= w_eff) begin
              cur_col_nxt = '0;
              cur_row_nxt = (row_inc >= h_eff) ? '0 : ttcb_pkg::ROW_W'(row_inc);
              state_nxt   = ttcb_pkg::S_SCROLL_BASE;
            end else begin
              cur_col_nxt = ttcb_pkg::COL_W'(col_inc);
            end
          end
        end
      end

      ttcb_pkg::S_RDATA: begin
        rd_char_nxt = oob_r ? '0 : ram_rdata;
        state_nxt   = ttcb_pkg::S_FIN;
      end

      ttcb_pkg::S_SCROLL_BASE: begin
        prod_nxt  = mul_p;
        cnt_nxt   = '0;
        state_nxt = ttcb_pkg::S_SCROLL;
      end

      // zero the row under the top pointer, one cell a cycle
      ttcb_pkg::S_SCROLL: begin
        ram_req.we    = !scr_oob;
        ram_req.addr  = ttcb_pkg::ADDR_W'(scr_addr);
        ram_req.wdata = '0;
        if (ttcb_pkg::WIDTH_W'(cnt_r) == w_eff - 1'b1) begin
          top_nxt   = (top_inc >= h_eff) ? '0 : ttcb_pkg::ROW_W'(top_inc);
          state_nxt = ttcb_pkg::S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ttcb_pkg::S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.addr  = clr_r;
        ram_req.wdata = '0;
        if (clr_r == '1) begin
          state_nxt = ttcb_pkg::S_FIN;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      ttcb_pkg::S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ttcb_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ttcb_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ttcb_pkg::S_IDLE;
      cur_col_r <= '0;
      cur_row_r <= '0;
      top_r     <= ttcb_pkg::ROW_W'(1);
    end else begin
      state_r   <= state_nxt;
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      top_r     <= top_nxt;
    end
    kind_r    <= kind_nxt;
    ch_r      <= ch_nxt;
    adv_r     <= adv_nxt;
    col_r     <= col_nxt;
    row_r     <= row_nxt;
    col_mod_r <= col_mod_nxt;
    row_mod_r <= row_mod_nxt;
    prod_r    <= prod_nxt;
    cnt_r     <= cnt_nxt;
    clr_r     <= clr_nxt;
    oob_r     <= oob_nxt;
    rd_char_r <= rd_char_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ttcb_pkg::WIDTH_RST;
      height_r <= ttcb_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ttcb_pkg::CFG_WIDTH:  width_r  <= cfg_data;
        ttcb_pkg::CFG_HEIGHT: height_r <= ttcb_pkg::HEIGHT_W'(cfg_data);
      endcase
    end
  end

  // output register holds a finished result while the next request is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_col_r  <= cur_col_r;
      out_row_r  <= cur_row_r;
      out_top_r  <= top_r;
      out_char_r <= rd_char_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_top_row    = out_top_r;
  assign out_read_char  = out_char_r;

  // read data is only captured the cycle after a memory read
  a_rdata_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ttcb_pkg::S_RDATA |-> $past(ram_req.re))
    else $error("read data captured without a preceding memory read");

  // a result appears only out of the finishing state
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ttcb_pkg::S_FIN))
    else $error("result loaded outside the finishing state");

  // remainder answers arrive only while the sequencer waits for them
  a_mod_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.done |-> (state_r == ttcb_pkg::S_MOD_COL || state_r == ttcb_pkg::S_MOD_ROW))
    else $error("remainder unit finished while nobody waited");

endmodule

>>> tb/sv/text_terminal_char_buffer_core_test.sv
// self-checking testbench for text_terminal_char_buffer_core: directed and random terminal
// requests with register changes between phases, results predicted by an in-bench shadow
// depends on ttcb_pkg and the core top level
`timescale 1ns / 1ps

module text_terminal_char_buffer_core_test;

  localparam int LIMIT_CYCLES = 750000;
  localparam int TAIL_CYCLES  = 200;

  typedef struct packed {
    logic [ttcb_pkg::COL_W-1:0]  cursor_col;
    logic [ttcb_pkg::ROW_W-1:0]  cursor_row;
    logic [ttcb_pkg::ROW_W-1:0]  top_row;
    logic [ttcb_pkg::CHAR_W-1:0] read_char;
  } term_status_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [ttcb_pkg::KIND_W-1:0]    in_kind;
  logic [ttcb_pkg::CHAR_W-1:0]    in_char_code;
  logic                           in_auto_advance;
  logic [ttcb_pkg::COL_W-1:0]     in_col;
  logic [ttcb_pkg::ROW_W-1:0]     in_row;
  logic                           out_valid;
  logic                           out_stall;
  logic [ttcb_pkg::COL_W-1:0]     out_cursor_col;
  logic [ttcb_pkg::ROW_W-1:0]     out_cursor_row;
  logic [ttcb_pkg::ROW_W-1:0]     out_top_row;
  logic [ttcb_pkg::CHAR_W-1:0]    out_read_char;
  logic                           cfg_we;
  logic [ttcb_pkg::CFG_IDX_W-1:0] cfg_addr;
  logic [ttcb_pkg::WIDTH_W-1:0]   cfg_data;

  text_terminal_char_buffer_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_char_code    (in_char_code),
    .in_auto_advance (in_auto_advance),
    .in_col          (in_col),
    .in_row          (in_row),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cursor_col  (out_cursor_col),
    .out_cursor_row  (out_cursor_row),
    .out_top_row     (out_top_row),
    .out_read_char   (out_read_char),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_data        (cfg_data)
  );

  // shadow copy of the terminal
  logic [ttcb_pkg::CHAR_W-1:0]   shadow_cells [ttcb_pkg::CELLS];
  bit                            cell_known [ttcb_pkg::CELLS];
  int unsigned                   shadow_col;
  int unsigned                   shadow_row;
  int unsigned                   shadow_top;
  logic [ttcb_pkg::WIDTH_W-1:0]  shadow_width;
  logic [ttcb_pkg::HEIGHT_W-1:0] shadow_height;

  term_status_t status_q [$];
  int unsigned  cycle_cnt;
  int unsigned  requests_sent;
  int unsigned  results_seen;
  int unsigned  mismatches;
  int unsigned  clears_sent;
  int unsigned  geometries_used;
  int unsigned  clear_budget;
  bit           calm;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned cols_in_use();
    if (shadow_width == 0) return 1;
    if (shadow_width > ttcb_pkg::MAX_COLS) return ttcb_pkg::MAX_COLS;
    return 32'(shadow_width);
  endfunction

  function automatic int unsigned rows_in_use();
    if (shadow_height == 0) return 1;
    if (shadow_height > ttcb_pkg::MAX_ROWS) return ttcb_pkg::MAX_ROWS;
    return 32'(shadow_height);
  endfunction

  function automatic void store_cell(input int unsigned addr,
                                     input logic [ttcb_pkg::CHAR_W-1:0] value);
    if (addr < ttcb_pkg::CELLS) begin
      shadow_cells[addr] = value;
      cell_known[addr]   = 1'b1;
    end
  endfunction

  // zero the row under the top pointer, then move the pointer on with wrap
  function automatic void scroll_screen();
    int unsigned base;
    base = shadow_top * cols_in_use();
    for (int unsigned i = 0; i < cols_in_use(); i++) store_cell(base + i, '0);
    shadow_top++;
    if (shadow_top >= rows_in_use()) shadow_top = 0;
  endfunction

  function automatic void advance_cursor();
    shadow_col++;
    if (shadow_col >= cols_in_use()) begin
      shadow_col = 0;
      shadow_row++;
      scroll_screen();
      if (shadow_row >= rows_in_use()) shadow_row = 0;
    end
  endfunction

  function automatic void put_char(input logic [ttcb_pkg::CHAR_W-1:0] ch, input logic adv);
    store_cell(shadow_row * cols_in_use() + shadow_col, ch);
    if (adv && ch != 0) advance_cursor();
  endfunction

  function automatic term_status_t predict_terminal_step(
    input logic [ttcb_pkg::KIND_W-1:0] kind, input logic [ttcb_pkg::CHAR_W-1:0] ch,
    input logic adv, input logic [ttcb_pkg::COL_W-1:0] col,
    input logic [ttcb_pkg::ROW_W-1:0] row);
    term_status_t status;
    int unsigned  next_row;
    int unsigned  addr;
    status.read_char = '0;
    case (kind)
      ttcb_pkg::K_TEXT: begin
        if (ch == ttcb_pkg::CH_NEWLINE) begin
          next_row = (shadow_row + 1) % rows_in_use();
          scroll_screen();
          shadow_col = 0;
          shadow_row = next_row % rows_in_use();
        end else if (ch == ttcb_pkg::CH_RETURN) begin
          shadow_col = 0;
          shadow_row = shadow_row % rows_in_use();
        end else begin
          put_char(ch, 1'b1);
        end
      end
      ttcb_pkg::K_RAW: put_char(ch, adv);
      ttcb_pkg::K_SETCUR: begin
        shadow_col = col % cols_in_use();
        shadow_row = row % rows_in_use();
      end
      ttcb_pkg::K_CLEAR: begin
        foreach (shadow_cells[i]) begin
          shadow_cells[i] = '0;
          cell_known[i]   = 1'b1;
        end
      end
      ttcb_pkg::K_READ: begin
        addr = (row % rows_in_use()) * cols_in_use() + (col % cols_in_use());
        if (addr < ttcb_pkg::CELLS) status.read_char = shadow_cells[addr];
      end
      default: ;
    endcase
    status.cursor_col = ttcb_pkg::COL_W'(shadow_col);
    status.cursor_row = ttcb_pkg::ROW_W'(shadow_row);
    status.top_row    = ttcb_pkg::ROW_W'(shadow_top);
    return status;
  endfunction

  function automatic logic [ttcb_pkg::CHAR_W-1:0] pick_text_char();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) return ttcb_pkg::CH_NEWLINE;
    if (roll < 18) return ttcb_pkg::CH_RETURN;
    if (roll < 75) return ttcb_pkg::CHAR_W'($urandom_range(8'h20, 8'h7e));
    return ttcb_pkg::CHAR_W'($urandom_range(0, 255));
  endfunction

  // one request on the input channel, predicted when accepted
  task automatic send_request(input logic [ttcb_pkg::KIND_W-1:0] kind,
                              input logic [ttcb_pkg::CHAR_W-1:0] ch,
                              input logic adv, input logic [ttcb_pkg::COL_W-1:0] col,
                              input logic [ttcb_pkg::ROW_W-1:0] row);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_char_code    <= ch;
    in_auto_advance <= adv;
    in_col          <= col;
    in_row          <= row;
    do @(posedge clk); while (in_stall);
    status_q.push_back(predict_terminal_step(kind, ch, adv, col, row));
    requests_sent++;
    if (kind == ttcb_pkg::K_CLEAR) clears_sent++;
  endtask

  task automatic send_text(input logic [ttcb_pkg::CHAR_W-1:0] ch);
    send_request(ttcb_pkg::K_TEXT, ch, 1'($urandom_range(0, 1)),
                 ttcb_pkg::COL_W'($urandom_range(0, 127)),
                 ttcb_pkg::ROW_W'($urandom_range(0, 63)));
  endtask

  task automatic send_raw(input logic [ttcb_pkg::CHAR_W-1:0] ch, input logic adv);
    send_request(ttcb_pkg::K_RAW, ch, adv, ttcb_pkg::COL_W'($urandom_range(0, 127)),
                 ttcb_pkg::ROW_W'($urandom_range(0, 63)));
  endtask

  task automatic send_setcur(input logic [ttcb_pkg::COL_W-1:0] col,
                             input logic [ttcb_pkg::ROW_W-1:0] row);
    send_request(ttcb_pkg::K_SETCUR, ttcb_pkg::CHAR_W'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), col, row);
  endtask

  task automatic send_clear();
    send_request(ttcb_pkg::K_CLEAR, ttcb_pkg::CHAR_W'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), ttcb_pkg::COL_W'($urandom_range(0, 127)),
                 ttcb_pkg::ROW_W'($urandom_range(0, 63)));
  endtask

  // cells that were never written hold nothing defined, so such reads are skipped
  task automatic send_read(input logic [ttcb_pkg::COL_W-1:0] col,
                           input logic [ttcb_pkg::ROW_W-1:0] row);
    int unsigned addr;
    addr = (row % rows_in_use()) * cols_in_use() + (col % cols_in_use());
    if (addr < ttcb_pkg::CELLS && cell_known[addr])
      send_request(ttcb_pkg::K_READ, ttcb_pkg::CHAR_W'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), col, row);
  endtask

  task automatic send_spare_kind();
    send_request(ttcb_pkg::KIND_W'(ttcb_pkg::K_READ) + ttcb_pkg::KIND_W'($urandom_range(1, 3)),
                 ttcb_pkg::CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 ttcb_pkg::COL_W'($urandom_range(0, 127)),
                 ttcb_pkg::ROW_W'($urandom_range(0, 63)));
  endtask

  // drop valid and wait until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (status_q.size() != 0);
  endtask

  task automatic set_geometry(input logic [ttcb_pkg::WIDTH_W-1:0] w,
                              input logic [ttcb_pkg::WIDTH_W-1:0] h);
    settle();
    cfg_we   <= 1'b1;
    cfg_addr <= ttcb_pkg::CFG_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    shadow_width = w;
    cfg_addr <= ttcb_pkg::CFG_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    shadow_height = h[ttcb_pkg::HEIGHT_W-1:0];
    cfg_we <= 1'b0;
    geometries_used++;
  endtask

  task automatic test_text_and_raw_writes();
    send_text(8'h41);
    send_read(0, 0);
    send_clear();
    send_text(ttcb_pkg::CH_RETURN);
    send_text(ttcb_pkg::CH_NEWLINE);
    send_text(8'h00);
    send_text(8'hff);
    send_text(8'h09);
    send_raw(8'h55, 1'b0);
    send_raw(8'h00, 1'b1);
    send_raw(8'h80, 1'b1);
    send_read(1, 1);
    send_read(2, 1);
  endtask

  task automatic test_cursor_and_read();
    // last cell of the screen: the write wraps to the first row and scrolls
    send_setcur(79, 29);
    send_text(8'h5a);
    send_read(79, 29);
    send_setcur(127, 63);
    send_read(127, 63);
    send_spare_kind();
    send_spare_kind();
  endtask

  task automatic test_geometry_extremes();
    set_geometry(1, 1);
    send_text(8'h31);
    send_text(ttcb_pkg::CH_NEWLINE);
    send_raw(8'h32, 1'b1);
    send_read(5, 7);
    set_geometry(ttcb_pkg::WIDTH_W'(ttcb_pkg::MAX_COLS), ttcb_pkg::WIDTH_W'(ttcb_pkg::MAX_ROWS));
    send_setcur(127, 63);
    send_text(8'h7e);
    send_read(127, 63);
    repeat (3) send_text(ttcb_pkg::CH_NEWLINE);
  endtask

  task automatic test_shrunken_cursor();
    // cursor and top pointer left beyond a smaller screen
    send_setcur(100, 50);
    set_geometry(10, 2);
    send_text(8'h41);
    send_read(3, 1);
    set_geometry(ttcb_pkg::WIDTH_W'(ttcb_pkg::MAX_COLS), ttcb_pkg::WIDTH_W'(ttcb_pkg::MAX_ROWS));
    send_setcur(90, 40);
    set_geometry(10, 2);
    send_text(ttcb_pkg::CH_RETURN);
    set_geometry(ttcb_pkg::WIDTH_W'(ttcb_pkg::MAX_COLS), ttcb_pkg::WIDTH_W'(ttcb_pkg::MAX_ROWS));
    send_setcur(90, 40);
    set_geometry(10, 2);
    send_text(ttcb_pkg::CH_NEWLINE);
    send_raw(8'h42, 1'b0);
  endtask

  task automatic test_saturation();
    set_geometry(0, 0);
    send_text(8'h61);
    send_text(8'h62);
    send_text(ttcb_pkg::CH_NEWLINE);
    send_read(9, 9);
    set_geometry(8'hff, 8'hff);
    send_setcur(127, 63);
    send_text(8'h63);
    send_read(127, 63);
  endtask

  task automatic test_random_traffic(input int unsigned count,
                                     input logic [ttcb_pkg::WIDTH_W-1:0] w,
                                     input logic [ttcb_pkg::WIDTH_W-1:0] h);
    int unsigned pick;
    set_geometry(w, h);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_text(pick_text_char());
      end else if (pick < 68) begin
        send_raw(ttcb_pkg::CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (pick < 78) begin
        send_setcur(ttcb_pkg::COL_W'($urandom_range(0, 127)),
                    ttcb_pkg::ROW_W'($urandom_range(0, 63)));
      end else if (pick < 95) begin
        // half the reads look at the cursor row, where text has just landed
        if ($urandom_range(0, 1) == 0)
          send_read(ttcb_pkg::COL_W'($urandom_range(0, 127)), ttcb_pkg::ROW_W'(shadow_row));
        else
          send_read(ttcb_pkg::COL_W'($urandom_range(0, 127)),
                    ttcb_pkg::ROW_W'($urandom_range(0, 63)));
      end else if (pick < 98) begin
        send_spare_kind();
      end else if (clear_budget > 0) begin
        clear_budget--;
        send_clear();
      end else begin
        send_text(ttcb_pkg::CH_NEWLINE);
      end
    end
  endtask

  task automatic test_quiet_tail();
    settle();
    calm = 1'b1;
    test_random_traffic(60, ttcb_pkg::WIDTH_W'($urandom_range(1, 16)),
                        ttcb_pkg::WIDTH_W'($urandom_range(1, 8)));
  endtask

  // receiver stalls in random bursts
  initial begin
    int unsigned burst;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && rst_n && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 10);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    term_status_t want;
    term_status_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_cursor_col, out_cursor_row, out_top_row, out_read_char};
      results_seen++;
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: col %0d row %0d top %0d char %02h",
                   got.cursor_col, got.cursor_row, got.top_row, got.read_char);
      end else begin
        want = status_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result %0d: expected col %0d row %0d top %0d char %02h,",
                      " got col %0d row %0d top %0d char %02h"},
                     results_seen, want.cursor_col, want.cursor_row, want.top_row,
                     want.read_char, got.cursor_col, got.cursor_row, got.top_row,
                     got.read_char);
        end
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("run stopped at the cycle limit with %0d results outstanding", status_q.size());
    $display("[text_terminal_char_buffer_core] ERROR");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_kind         = ttcb_pkg::K_TEXT;
    in_char_code    = '0;
    in_auto_advance = 1'b0;
    in_col          = '0;
    in_row          = '0;
    cfg_we          = 1'b0;
    cfg_addr        = ttcb_pkg::CFG_WIDTH;
    cfg_data        = '0;
    calm            = 1'b0;
    clear_budget    = 4;
    requests_sent   = 0;
    results_seen    = 0;
    mismatches      = 0;
    clears_sent     = 0;
    geometries_used = 0;
    shadow_col      = 0;
    shadow_row      = 0;
    shadow_top      = 1;
    shadow_width    = ttcb_pkg::WIDTH_RST;
    shadow_height   = ttcb_pkg::HEIGHT_RST;
    foreach (cell_known[i]) cell_known[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_text_and_raw_writes();
    test_cursor_and_read();
    test_geometry_extremes();
    test_shrunken_cursor();
    test_saturation();
    test_random_traffic(140, 8, 4);
    test_random_traffic(80, ttcb_pkg::WIDTH_W'(ttcb_pkg::MAX_COLS),
                        ttcb_pkg::WIDTH_W'(ttcb_pkg::MAX_ROWS));
    test_random_traffic(60, 1, 1);
    test_random_traffic(60, 3, ttcb_pkg::WIDTH_W'(ttcb_pkg::MAX_ROWS));
    test_random_traffic(60, ttcb_pkg::WIDTH_W'(ttcb_pkg::MAX_COLS), 2);
    test_random_traffic(50, ttcb_pkg::WIDTH_W'($urandom_range(1, 24)),
                        ttcb_pkg::WIDTH_W'($urandom_range(1, 12)));
    test_quiet_tail();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d requests (%0d full clears) over %0d screen geometries",
             requests_sent, clears_sent, geometries_used);
    $display("checked %0d results in %0d cycles, %0d mismatches",
             results_seen, cycle_cnt, mismatches);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("[text_terminal_char_buffer_core] OK");
    end else begin
      $display("%0d results never arrived", status_q.size());
      $display("[text_terminal_char_buffer_core] ERROR");
    end
    $finish;
  end

endmodule
